// ===== design/peer_registry_table_assert.svh =====
// Assertion macros of the peer registry table checker
`ifndef PEER_REGISTRY_TABLE_ASSERT_SVH
`define PEER_REGISTRY_TABLE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define PRT_ASSERT_IMPLY(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error("peer_registry_table check failed");

// Check that a condition implies a consequence in the next cycle
`define PRT_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error("peer_registry_table check failed");

`endif

// ===== design/prt_pkg.sv =====
// Types, constants and codes of the peer registry table
package prt_pkg;

    localparam int MAX_ID   = 31;
    localparam int SLOT_W   = $clog2(MAX_ID);
    localparam int ID_W     = 8;
    localparam int NF_W     = 9;
    localparam int ADDR_W   = 48;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_ID - 1);

    // Request commands
    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_QUERY    = 2'd1;
    localparam logic [1:0] CMD_UPDATE   = 2'd2;
    localparam logic [1:0] CMD_STATUS   = 2'd3;

    // Result codes
    localparam logic [2:0] RC_ASSIGNED  = 3'd0;
    localparam logic [2:0] RC_DUPLICATE = 3'd1;
    localparam logic [2:0] RC_EXHAUSTED = 3'd2;
    localparam logic [2:0] RC_INFO      = 3'd3;
    localparam logic [2:0] RC_UNKNOWN   = 3'd4;
    localparam logic [2:0] RC_UPDATED   = 3'd5;
    localparam logic [2:0] RC_STATUS    = 3'd6;

    // Result operations the controller asks the datapath to perform
    localparam logic [2:0] RES_NONE     = 3'd0;
    localparam logic [2:0] RES_DUP      = 3'd1;
    localparam logic [2:0] RES_ASSIGN   = 3'd2;
    localparam logic [2:0] RES_UNKNOWN  = 3'd3;
    localparam logic [2:0] RES_INFO     = 3'd4;
    localparam logic [2:0] RES_UPDATE   = 3'd5;
    localparam logic [2:0] RES_STATUS   = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] src_ip;
        logic [15:0] src_udp_port;
        logic [31:0] lan_ip;
        logic [15:0] lan_port;
        logic [7:0]  target_id;
    } prt_in_t;

    typedef struct packed {
        logic        respond;
        logic [2:0]  result_code;
        logic [7:0]  id_out;
        logic [31:0] peer_public_ip;
        logic [15:0] peer_public_port;
        logic [31:0] peer_local_ip;
        logic [15:0] peer_local_port;
    } prt_out_t;

    typedef struct packed {
        logic       load;
        logic       scan_rd;
        logic       tgt_rd;
        logic       emit;
        logic [2:0] res_op;
    } prt_ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       hit;
        logic       miss;
        logic       tgt_ok;
        logic       out_busy;
    } prt_stat_t;

endpackage

// ===== design/peer_registry_table.sv =====
// Top level of the peer registry table
//
// Rendezvous registry of up to 31 peers. Each request item on the s_ channel
// (register, query, update, status) yields exactly one result item on the m_
// channel; the respond bit tells whether a reply packet would be sent.
// Items are worked one at a time: s_ready is high only while the block idles.
// Register and query scan the slot store one slot per cycle through a single
// registered memory read port; a full scan ends at the last slot. A hit ends
// the scan early: a register hit ends with the duplicate result, and a query
// hit with a valid target then reads the target slot for its result.
// Update and status need no scan and go straight to their result step.
// s_ready rises as the result enters the output register, so the block takes
// no new item before it is through with the last one. The result sits in an
// output register; the block takes the next item while it waits, and when the
// receiver stalls it finishes that item and holds in its last step until the
// output register frees.
// Reset (aresetn low, synchronous) clears all slot valid bits and the ID
// counter at once; the slot memories need no clearing pass.
module peer_registry_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  prt_pkg::prt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output prt_pkg::prt_out_t m_data
);
    import prt_pkg::*;

    prt_ctrl_t ctrl;
    prt_stat_t stat;

    prt_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_cmd  (s_data.cmd),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    prt_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctrl    (ctrl),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== design/prt_controller.sv =====
// Sequencing state machine of the peer registry table
module prt_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         in_cmd,
    input  prt_pkg::prt_stat_t stat,
    output prt_pkg::prt_ctrl_t ctrl
);
    import prt_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_TGT_RD   = 3'd2;
    localparam logic [2:0] S_TGT_DATA = 3'd3;
    localparam logic [2:0] S_EXEC     = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Pick the next step and the datapath commands
    always_comb begin
        state_next   = state_reg;
        ctrl         = '0;
        ctrl.res_op  = RES_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctrl.load = 1'b1;
                    if (in_cmd == CMD_REGISTER || in_cmd == CMD_QUERY) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                ctrl.scan_rd = 1'b1;
                if (stat.hit) begin
                    if (stat.cmd == CMD_REGISTER) begin
                        ctrl.res_op = RES_DUP;
                        state_next  = S_FINISH;
                    end else if (stat.tgt_ok) begin
                        state_next  = S_TGT_RD;
                    end else begin
                        ctrl.res_op = RES_UNKNOWN;
                        state_next  = S_FINISH;
                    end
                end else if (stat.miss) begin
                    ctrl.res_op = (stat.cmd == CMD_REGISTER) ? RES_ASSIGN : RES_UNKNOWN;
                    state_next  = S_FINISH;
                end
            end
            S_TGT_RD: begin
                ctrl.tgt_rd = 1'b1;
                state_next  = S_TGT_DATA;
            end
            S_TGT_DATA: begin
                ctrl.res_op = RES_INFO;
                state_next  = S_FINISH;
            end
            S_EXEC: begin
                ctrl.res_op = (stat.cmd == CMD_UPDATE) ? RES_UPDATE : RES_STATUS;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                // Hold until the output register is free
                if (!stat.out_busy) begin
                    ctrl.emit  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/prt_datapath.sv =====
// Slot store, scan pipeline and result registers of the peer registry table
module prt_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  prt_pkg::prt_in_t   s_data,
    input  prt_pkg::prt_ctrl_t ctrl,
    output prt_pkg::prt_stat_t stat,
    output logic               m_valid,
    input  logic               m_ready,
    output prt_pkg::prt_out_t  m_data
);
    import prt_pkg::*;

    // Slot memories: public {ip, port} and local {ip, port}
    logic [ADDR_W-1:0] pub_mem [0:MAX_ID-1];
    logic [ADDR_W-1:0] loc_mem [0:MAX_ID-1];

    prt_in_t           req_reg;
    prt_out_t          res_reg, res_next;
    prt_out_t          m_data_reg;
    logic              m_valid_reg, m_valid_next;
    logic [MAX_ID-1:0] valid_reg, valid_next;
    logic [NF_W-1:0]   nf_reg, nf_next;
    logic [SLOT_W-1:0] scan_idx_reg, scan_idx_next;
    logic              issued_all_reg, issued_all_next;
    logic              rd_live_reg, rd_live_next;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [ADDR_W-1:0] rd_pub_reg, rd_loc_reg;

    logic [SLOT_W-1:0] rd_addr;
    logic [ID_W-1:0]   tid_dec;
    logic [SLOT_W-1:0] tgt_slot;
    logic              tgt_ok;
    logic              slot_match;
    logic              hit;
    logic [NF_W-1:0]   nf_eff;
    logic [NF_W-1:0]   nf_slot;
    logic              room;
    logic              pub_we, loc_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [ADDR_W-1:0] wr_loc;

    // Resolve the target ID against the valid slots
    assign tid_dec  = req_reg.target_id - ID_W'(1);
    assign tgt_slot = tid_dec[SLOT_W-1:0];
    assign tgt_ok   = (req_reg.target_id != '0) && (req_reg.target_id <= ID_W'(MAX_ID))
                      && valid_reg[tgt_slot];

    // Compare the slot read in the previous cycle
    assign slot_match = (req_reg.cmd == CMD_REGISTER)
                      ? (rd_loc_reg[ADDR_W-1:16] == req_reg.lan_ip)
                      : (rd_pub_reg == {req_reg.src_ip, req_reg.src_udp_port});
    assign hit = rd_live_reg && valid_reg[rd_idx_reg] && slot_match;

    // Next ID to hand out, where zero stands for one
    assign nf_eff  = (nf_reg == '0) ? NF_W'(1) : nf_reg;
    assign nf_slot = nf_eff - NF_W'(1);
    assign room    = (nf_eff <= NF_W'(MAX_ID));

    assign rd_addr = ctrl.tgt_rd ? tgt_slot : scan_idx_reg;

    assign stat.cmd      = req_reg.cmd;
    assign stat.hit      = hit;
    assign stat.miss     = rd_live_reg && !hit && (rd_idx_reg == SLOT_LAST);
    assign stat.tgt_ok   = tgt_ok;
    assign stat.out_busy = m_valid_reg && !m_ready;

    // Advance the scan address one slot per cycle
    always_comb begin
        scan_idx_next   = scan_idx_reg;
        issued_all_next = issued_all_reg;
        rd_live_next    = 1'b0;
        if (ctrl.load) begin
            scan_idx_next   = '0;
            issued_all_next = 1'b0;
        end else if (ctrl.scan_rd && !issued_all_reg) begin
            rd_live_next = 1'b1;
            if (scan_idx_reg == SLOT_LAST) begin
                issued_all_next = 1'b1;
            end else begin
                scan_idx_next = scan_idx_reg + SLOT_W'(1);
            end
        end
    end

    // Form the result and the store updates
    always_comb begin
        res_next   = res_reg;
        valid_next = valid_reg;
        nf_next    = nf_reg;
        pub_we     = 1'b0;
        loc_we     = 1'b0;
        wr_addr    = tgt_slot;
        wr_loc     = {req_reg.lan_ip, req_reg.lan_port};
        case (ctrl.res_op)
            RES_NONE: begin
            end
            RES_DUP: begin
                res_next             = '0;
                res_next.result_code = RC_DUPLICATE;
            end
            RES_ASSIGN: begin
                res_next = '0;
                if (room) begin
                    wr_addr              = nf_slot[SLOT_W-1:0];
                    pub_we               = 1'b1;
                    loc_we               = 1'b1;
                    valid_next[wr_addr]  = 1'b1;
                    nf_next              = nf_eff + NF_W'(1);
                    res_next.respond     = 1'b1;
                    res_next.result_code = RC_ASSIGNED;
                    res_next.id_out      = nf_eff[ID_W-1:0];
                end else begin
                    nf_next              = nf_eff;
                    res_next.result_code = RC_EXHAUSTED;
                end
            end
            RES_UNKNOWN: begin
                res_next             = '0;
                res_next.result_code = RC_UNKNOWN;
            end
            RES_INFO: begin
                res_next.respond          = 1'b1;
                res_next.result_code      = RC_INFO;
                res_next.id_out           = req_reg.target_id;
                res_next.peer_public_ip   = rd_pub_reg[ADDR_W-1:16];
                res_next.peer_public_port = rd_pub_reg[15:0];
                res_next.peer_local_ip    = rd_loc_reg[ADDR_W-1:16];
                res_next.peer_local_port  = rd_loc_reg[15:0];
            end
            RES_UPDATE: begin
                res_next = '0;
                if (tgt_ok) begin
                    loc_we               = 1'b1;
                    res_next.result_code = RC_UPDATED;
                end else begin
                    res_next.result_code = RC_UNKNOWN;
                end
            end
            RES_STATUS: begin
                res_next             = '0;
                res_next.respond     = 1'b1;
                res_next.result_code = RC_STATUS;
                res_next.id_out      = ID_W'((req_reg.lan_ip == req_reg.src_ip)
                                             && (req_reg.lan_port == req_reg.src_udp_port));
            end
            default: begin
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            nf_reg         <= '0;
            scan_idx_reg   <= '0;
            issued_all_reg <= 1'b0;
            rd_live_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            nf_reg         <= nf_next;
            scan_idx_reg   <= scan_idx_next;
            issued_all_reg <= issued_all_next;
            rd_live_reg    <= rd_live_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            req_reg <= s_data;
        end
        if (ctrl.emit) begin
            m_data_reg <= res_reg;
        end
        res_reg    <= res_next;
        rd_idx_reg <= scan_idx_reg;
    end

    // Slot memories with registered read
    always_ff @(posedge aclk) begin
        rd_pub_reg <= pub_mem[rd_addr];
        rd_loc_reg <= loc_mem[rd_addr];
        if (pub_we) begin
            pub_mem[wr_addr] <= {req_reg.src_ip, req_reg.src_udp_port};
        end
        if (loc_we) begin
            loc_mem[wr_addr] <= wr_loc;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/prt_checker.sv =====
// Port-level checks of the peer registry table and their bind
`include "peer_registry_table_assert.svh"

module prt_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input prt_pkg::prt_out_t m_data
);
    import prt_pkg::*;

    // Stalled result holds
    `PRT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // One request at a time: accept closes the input
    `PRT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

    // Silent results carry only the no-reply codes
    `PRT_ASSERT_IMPLY(a_silent_codes, aclk, aresetn, m_valid && !m_data.respond,
        m_data.result_code == RC_DUPLICATE || m_data.result_code == RC_EXHAUSTED ||
        m_data.result_code == RC_UNKNOWN || m_data.result_code == RC_UPDATED)

    // Addresses are returned only with peer info
    `PRT_ASSERT_IMPLY(a_addr_zero, aclk, aresetn, m_valid && m_data.result_code != RC_INFO,
        m_data.peer_public_ip == '0 && m_data.peer_public_port == '0 &&
        m_data.peer_local_ip == '0 && m_data.peer_local_port == '0)

    // Status reports a single match flag
    `PRT_ASSERT_IMPLY(a_status_flag, aclk, aresetn, m_valid && m_data.result_code == RC_STATUS,
        m_data.id_out[7:1] == '0 && m_data.respond)

endmodule

bind peer_registry_table prt_checker u_prt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/peer_registry_monitor.sv =====
// Request/result monitor for the peer registry table: predicts each result and compares it
`timescale 1ns / 100ps

module peer_registry_monitor (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  prt_pkg::prt_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  prt_pkg::prt_out_t m_data,
    output int                error_count,
    output int                pending_items
);
    import prt_pkg::*;

    // Shadow copy of the registry
    logic [NF_W-1:0] next_id;
    logic            tbl_valid    [MAX_ID];
    logic [31:0]     tbl_pub_ip   [MAX_ID];
    logic [15:0]     tbl_pub_port [MAX_ID];
    logic [31:0]     tbl_loc_ip   [MAX_ID];
    logic [15:0]     tbl_loc_port [MAX_ID];

    prt_out_t pending_replies[$];

    // Work out the result of one request and advance the shadow registry
    function automatic prt_out_t resolve_request(input prt_in_t req);
        prt_out_t rsp;
        int       tid;
        int       tgt_slot;
        int       req_slot;
        logic     dup;
        rsp      = '0;
        tid      = int'(req.target_id);
        tgt_slot = -1;
        req_slot = -1;
        dup      = 1'b0;
        if (tid >= 1 && tid <= MAX_ID) begin
            if (tbl_valid[tid-1]) tgt_slot = tid - 1;
        end
        case (req.cmd)
            CMD_REGISTER: begin
                for (int i = 0; i < MAX_ID; i++) begin
                    if (tbl_valid[i] && tbl_loc_ip[i] == req.lan_ip) dup = 1'b1;
                end
                if (dup) begin
                    rsp.result_code = RC_DUPLICATE;
                end else begin
                    if (next_id == 0) next_id = NF_W'(1);
                    if (next_id <= MAX_ID) begin
                        tbl_valid[next_id-1]    = 1'b1;
                        tbl_pub_ip[next_id-1]   = req.src_ip;
                        tbl_pub_port[next_id-1] = req.src_udp_port;
                        tbl_loc_ip[next_id-1]   = req.lan_ip;
                        tbl_loc_port[next_id-1] = req.lan_port;
                        rsp.respond     = 1'b1;
                        rsp.result_code = RC_ASSIGNED;
                        rsp.id_out      = next_id[7:0];
                        next_id         = next_id + 1'b1;
                    end else begin
                        rsp.result_code = RC_EXHAUSTED;
                    end
                end
            end
            CMD_QUERY: begin
                // lowest matching slot identifies the requester
                for (int i = 0; i < MAX_ID; i++) begin
                    if (req_slot < 0 && tbl_valid[i] && tbl_pub_ip[i] == req.src_ip &&
                        tbl_pub_port[i] == req.src_udp_port) req_slot = i;
                end
                if (req_slot < 0 || tgt_slot < 0) begin
                    rsp.result_code = RC_UNKNOWN;
                end else begin
                    rsp.respond          = 1'b1;
                    rsp.result_code      = RC_INFO;
                    rsp.id_out           = req.target_id;
                    rsp.peer_public_ip   = tbl_pub_ip[tgt_slot];
                    rsp.peer_public_port = tbl_pub_port[tgt_slot];
                    rsp.peer_local_ip    = tbl_loc_ip[tgt_slot];
                    rsp.peer_local_port  = tbl_loc_port[tgt_slot];
                end
            end
            CMD_UPDATE: begin
                if (tgt_slot < 0) begin
                    rsp.result_code = RC_UNKNOWN;
                end else begin
                    tbl_loc_ip[tgt_slot]   = req.lan_ip;
                    tbl_loc_port[tgt_slot] = req.lan_port;
                    rsp.result_code        = RC_UPDATED;
                end
            end
            default: begin
                rsp.respond     = 1'b1;
                rsp.result_code = RC_STATUS;
                rsp.id_out      = (req.lan_ip == req.src_ip &&
                                   req.lan_port == req.src_udp_port) ? 8'd1 : 8'd0;
            end
        endcase
        return rsp;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            error_count++;
            $error("result field %s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        end
    endtask

    // Predict on each accepted request, compare on each accepted result
    always @(posedge aclk) begin
        prt_out_t exp_rsp;
        if (!aresetn) begin
            next_id = '0;
            for (int i = 0; i < MAX_ID; i++) tbl_valid[i] = 1'b0;
            pending_replies.delete();
        end else begin
            if (s_valid && s_ready)
                pending_replies = {pending_replies, resolve_request(s_data)};
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    error_count++;
                    $error("result item with no request outstanding: %h", m_data);
                end else begin
                    exp_rsp = pending_replies.pop_front();
                    check_field("respond", 32'(exp_rsp.respond), 32'(m_data.respond));
                    check_field("result_code", 32'(exp_rsp.result_code),
                                32'(m_data.result_code));
                    check_field("id_out", 32'(exp_rsp.id_out), 32'(m_data.id_out));
                    check_field("peer_public_ip", exp_rsp.peer_public_ip,
                                m_data.peer_public_ip);
                    check_field("peer_public_port", 32'(exp_rsp.peer_public_port),
                                32'(m_data.peer_public_port));
                    check_field("peer_local_ip", exp_rsp.peer_local_ip,
                                m_data.peer_local_ip);
                    check_field("peer_local_port", 32'(exp_rsp.peer_local_port),
                                32'(m_data.peer_local_port));
                end
            end
        end
        pending_items = pending_replies.size();
    end

endmodule

// ===== tb/sv/peer_registry_table_tb.sv =====
// Top of the peer registry table testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module peer_registry_table_tb;
    import prt_pkg::*;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    prt_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    prt_out_t m_data;

    int error_count;
    int pending_items;

    // sender burst bookkeeping and receiver stall pattern
    int burst_left = 0;
    int rdy_left   = 0;

    // addresses already offered for registration, reused to hit stored peers
    logic [31:0] pub_ip_pool[$];
    logic [15:0] pub_port_pool[$];
    logic [31:0] loc_ip_pool[$];

    peer_registry_table uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    peer_registry_monitor monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .error_count   (error_count),
        .pending_items (pending_items)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Alternate ready and stall stretches, sometimes a long stretch without stalls
    always @(posedge aclk) begin
        if (rdy_left > 0) begin
            rdy_left <= rdy_left - 1;
        end else if (m_ready) begin
            m_ready  <= 1'b0;
            rdy_left <= $urandom_range(0, 30);
        end else begin
            m_ready  <= 1'b1;
            rdy_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(0, 40);
        end
    end

    function automatic prt_in_t mk_req(input logic [1:0] cmd, input logic [31:0] sip,
                                       input logic [15:0] sport, input logic [31:0] lip,
                                       input logic [15:0] lport, input logic [7:0] tid);
        prt_in_t req;
        req.cmd          = cmd;
        req.src_ip       = sip;
        req.src_udp_port = sport;
        req.lan_ip       = lip;
        req.lan_port     = lport;
        req.target_id    = tid;
        return req;
    endfunction

    // Offer one request item, hold it until accepted, then maybe pause the sender
    task automatic send_request(input prt_in_t req);
        int gap;
        s_data  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic logic [7:0] pick_target();
        return ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, MAX_ID + 1));
    endfunction

    initial begin
        prt_in_t req;
        int      pick;
        int      idx;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty registry: query and update find nobody
        send_request(mk_req(CMD_QUERY, 32'h0A00_0001, 16'h1F90, 32'h0, 16'h0, 8'd1));
        send_request(mk_req(CMD_UPDATE, 32'h0, 16'h0, 32'hC0A8_0001, 16'h0050, 8'd1));
        // register, duplicate local IP, shared public address, extremes
        send_request(mk_req(CMD_REGISTER, 32'h0A00_0001, 16'h1F90, 32'hC0A8_0001,
                            16'h0050, 8'd0));
        send_request(mk_req(CMD_REGISTER, 32'h0B00_0002, 16'h1234, 32'hC0A8_0001,
                            16'h0099, 8'd7));
        send_request(mk_req(CMD_REGISTER, 32'h0A00_0001, 16'h1F90, 32'hC0A8_0002,
                            16'h0051, 8'd0));
        send_request(mk_req(CMD_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                            16'hFFFF, 8'hFF));
        send_request(mk_req(CMD_REGISTER, 32'h0, 16'h0, 32'h0, 16'h0, 8'h0));
        // queries: hit, target zero, beyond range, never assigned, unknown requester
        send_request(mk_req(CMD_QUERY, 32'h0A00_0001, 16'h1F90, 32'h0, 16'h0, 8'd2));
        send_request(mk_req(CMD_QUERY, 32'h0A00_0001, 16'h1F90, 32'h0, 16'h0, 8'd0));
        send_request(mk_req(CMD_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 8'hFF));
        send_request(mk_req(CMD_QUERY, 32'h0, 16'h0, 32'h0, 16'h0, 8'd32));
        send_request(mk_req(CMD_QUERY, 32'h0A00_0001, 16'h1F90, 32'h0, 16'h0, 8'd31));
        send_request(mk_req(CMD_QUERY, 32'h0A00_0001, 16'h1F91, 32'h0, 16'h0, 8'd1));
        // updates: known ID, zero ID, out of range ID
        send_request(mk_req(CMD_UPDATE, 32'h0, 16'h0, 32'hC0A8_0055, 16'hBEEF, 8'd2));
        send_request(mk_req(CMD_UPDATE, 32'h0, 16'h0, 32'hC0A8_0056, 16'hBEEE, 8'd0));
        send_request(mk_req(CMD_UPDATE, 32'h0, 16'h0, 32'hC0A8_0057, 16'hBEED, 8'd200));
        send_request(mk_req(CMD_QUERY, 32'h0, 16'h0, 32'h0, 16'h0, 8'd2));
        // status: match, port mismatch, all ones, all zero, IP mismatch
        send_request(mk_req(CMD_STATUS, 32'h0A00_0001, 16'h1F90, 32'h0A00_0001,
                            16'h1F90, 8'd0));
        send_request(mk_req(CMD_STATUS, 32'h0A00_0001, 16'h1F90, 32'h0A00_0001,
                            16'h1F91, 8'd0));
        send_request(mk_req(CMD_STATUS, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                            16'hFFFF, 8'hFF));
        send_request(mk_req(CMD_STATUS, 32'h0, 16'h0, 32'h0, 16'h0, 8'h0));
        send_request(mk_req(CMD_STATUS, 32'h0A00_0001, 16'h1F90, 32'h8A00_0001,
                            16'h1F90, 8'd0));
        // the old local IP of an updated peer is free again
        send_request(mk_req(CMD_REGISTER, 32'h0C00_0003, 16'h4000, 32'hC0A8_0002,
                            16'h0051, 8'd0));
        send_request(mk_req(CMD_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 8'd5));

        // Random traffic, mostly aimed at stored peers
        for (int n = 0; n < 1300; n++) begin
            req = mk_req(2'($urandom()), $urandom(), 16'($urandom()), $urandom(),
                         16'($urandom()), 8'($urandom()));
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                req.cmd = CMD_REGISTER;
                if (pub_ip_pool.size() > 0 && $urandom_range(0, 3) == 0) begin
                    idx              = $urandom_range(0, pub_ip_pool.size() - 1);
                    req.src_ip       = pub_ip_pool[idx];
                    req.src_udp_port = pub_port_pool[idx];
                end
                if (loc_ip_pool.size() > 0 && $urandom_range(0, 3) == 0)
                    req.lan_ip = loc_ip_pool[$urandom_range(0, loc_ip_pool.size() - 1)];
                if (pub_ip_pool.size() < 40) begin
                    pub_ip_pool   = {pub_ip_pool, req.src_ip};
                    pub_port_pool = {pub_port_pool, req.src_udp_port};
                    loc_ip_pool   = {loc_ip_pool, req.lan_ip};
                end
            end else if (pick < 60) begin
                req.cmd       = CMD_QUERY;
                req.target_id = pick_target();
                if (pub_ip_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
                    idx              = $urandom_range(0, pub_ip_pool.size() - 1);
                    req.src_ip       = pub_ip_pool[idx];
                    req.src_udp_port = pub_port_pool[idx];
                end
            end else if (pick < 80) begin
                req.cmd       = CMD_UPDATE;
                req.target_id = pick_target();
                if (loc_ip_pool.size() > 0 && $urandom_range(0, 4) == 0)
                    req.lan_ip = loc_ip_pool[$urandom_range(0, loc_ip_pool.size() - 1)];
            end else begin
                req.cmd = CMD_STATUS;
                if ($urandom_range(0, 1) == 0) begin
                    req.lan_ip   = req.src_ip;
                    req.lan_port = req.src_udp_port;
                end else if ($urandom_range(0, 1) == 0) begin
                    req.lan_ip = req.src_ip;
                end
            end
            send_request(req);
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then watch for stray ones
        @(posedge aclk);
        while (pending_items != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
